@@ rtl/core/vic_pkg.sv @@
// vic_pkg: shared types and constants for the vectored interrupt controller.
// Beat structs for the command and result channels, command codes, defaults.
// No dependencies.
package vic_pkg;

  localparam int NUM_BANKS_DEF      = 4;
  localparam int LINES_PER_BANK_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int LINE_W = 7;
  localparam int BANK_W = 2;
  localparam int DATA_W = 32;
  localparam int VEC_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENABLE      = 3'd0,
    CMD_DISABLE     = 3'd1,
    CMD_LOAD_RAW    = 3'd2,
    CMD_SOFT_SET    = 3'd3,
    CMD_SOFT_CLEAR  = 3'd4,
    CMD_READ_STATUS = 3'd5,
    CMD_ACK         = 3'd6
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [LINE_W-1:0] line;
    logic [BANK_W-1:0] bank;
    logic [DATA_W-1:0] data;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [VEC_W-1:0]  vector;
    logic              vector_valid;
    logic              any_pending;
  } out_beat_t;

  // acknowledge pick from the priority encoder
  typedef struct packed {
    logic             found;
    logic [VEC_W-1:0] vector;
  } ack_t;

  // result queue occupancy
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/core/vic_prio_enc.sv @@
// vic_prio_enc: lowest pending line across all banks, first bank wins.
// Pure combinational; uses vic_pkg for ack_t and widths.
module vic_prio_enc #(
  parameter int NUM_BANKS      = vic_pkg::NUM_BANKS_DEF,
  parameter int LINES_PER_BANK = vic_pkg::LINES_PER_BANK_DEF
) (
  input  logic [NUM_BANKS-1:0][LINES_PER_BANK-1:0] status,
  output logic [NUM_BANKS-1:0][LINES_PER_BANK-1:0] pick,
  output vic_pkg::ack_t                            ack
);

  localparam int LBW = (LINES_PER_BANK > 1) ? $clog2(LINES_PER_BANK) : 1;
  localparam int VFW = $clog2(NUM_BANKS * LINES_PER_BANK + 1);
  localparam int VXW = (VFW > vic_pkg::VEC_W) ? VFW : vic_pkg::VEC_W;

  logic [NUM_BANKS-1:0]      bank_hit;
  logic [NUM_BANKS-1:0]      first_bank;
  logic [LINES_PER_BANK-1:0] sel_word;
  logic [LINES_PER_BANK-1:0] low_bit;
  logic [LBW-1:0]            offset;
  logic [VXW-1:0]            base;
  logic [VXW-1:0]            vec_full;

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_hit[b] = |status[b];
    end
    // isolate lowest set bit
    first_bank = bank_hit & (~bank_hit + 1'b1);

    sel_word = '0;
    base     = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (first_bank[b]) begin
        sel_word = sel_word | status[b];
        base     = base | VXW'(b * LINES_PER_BANK);
      end
    end
    low_bit = sel_word & (~sel_word + 1'b1);

    offset = '0;
    for (int i = 0; i < LINES_PER_BANK; i++) begin
      if (low_bit[i]) offset = offset | LBW'(i);
    end

    for (int b = 0; b < NUM_BANKS; b++) begin
      pick[b] = first_bank[b] ? low_bit : '0;
    end

    vec_full   = base + VXW'(offset);
    ack.found  = |bank_hit;
    ack.vector = vec_full[vic_pkg::VEC_W-1:0];
  end

endmodule

@@ rtl/core/vic_core.sv @@
// vic_core: per-line enable, raw level and soft-pending registers plus
// command decode and next-state logic. Uses vic_pkg and vic_prio_enc.
module vic_core #(
  parameter int NUM_BANKS      = vic_pkg::NUM_BANKS_DEF,
  parameter int LINES_PER_BANK = vic_pkg::LINES_PER_BANK_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_acc,
  input  vic_pkg::in_beat_t cmd_beat,
  output vic_pkg::out_beat_t res_beat
);

  localparam int LBW = (LINES_PER_BANK > 1) ? $clog2(LINES_PER_BANK) : 1;
  localparam int LFW = $clog2(NUM_BANKS * LINES_PER_BANK + 1);
  localparam int LXW = (LFW > vic_pkg::LINE_W + 1) ? LFW : vic_pkg::LINE_W + 1;

  typedef logic [NUM_BANKS-1:0][LINES_PER_BANK-1:0] bank_arr_t;

  bank_arr_t en_r, en_nxt;
  bank_arr_t raw_r, raw_nxt;
  bank_arr_t soft_r, soft_nxt;
  bank_arr_t status;
  bank_arr_t pick;
  vic_pkg::ack_t ack;

  logic [LXW-1:0]            line_x;
  logic [NUM_BANKS-1:0]      line_hit;
  logic [NUM_BANKS-1:0]      bank_hit;
  logic [LBW-1:0]            lbit;
  logic [LINES_PER_BANK-1:0] lanes;

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      status[b] = (raw_r[b] | soft_r[b]) & en_r[b];
    end
  end

  vic_prio_enc #(
    .NUM_BANKS      (NUM_BANKS),
    .LINES_PER_BANK (LINES_PER_BANK)
  ) u_prio (
    .status (status),
    .pick   (pick),
    .ack    (ack)
  );

  // line number -> bank hit and bit within bank, by range compare
  always_comb begin
    line_x = LXW'(cmd_beat.line);
    lbit   = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      line_hit[b] = (line_x >= LXW'(b * LINES_PER_BANK)) &&
                    (line_x <  LXW'((b + 1) * LINES_PER_BANK));
      if (line_hit[b]) lbit = lbit | LBW'(line_x - LXW'(b * LINES_PER_BANK));
      bank_hit[b] = (int'(cmd_beat.bank) == b);
    end
    lanes = cmd_beat.data[LINES_PER_BANK-1:0];
  end

  always_comb begin
    en_nxt   = en_r;
    raw_nxt  = raw_r;
    soft_nxt = soft_r;
    res_beat = '0;
    if (cmd_acc) begin
      unique case (cmd_beat.cmd)
        vic_pkg::CMD_ENABLE: begin
          for (int b = 0; b < NUM_BANKS; b++) begin
            if (line_hit[b]) en_nxt[b][lbit] = 1'b1;
          end
        end
        vic_pkg::CMD_DISABLE: begin
          for (int b = 0; b < NUM_BANKS; b++) begin
            if (line_hit[b]) en_nxt[b][lbit] = 1'b0;
          end
        end
        vic_pkg::CMD_LOAD_RAW: begin
          for (int b = 0; b < NUM_BANKS; b++) begin
            if (bank_hit[b]) raw_nxt[b] = lanes;
          end
        end
        vic_pkg::CMD_SOFT_SET: begin
          for (int b = 0; b < NUM_BANKS; b++) begin
            if (bank_hit[b]) soft_nxt[b] = soft_r[b] | lanes;
          end
        end
        vic_pkg::CMD_SOFT_CLEAR: begin
          for (int b = 0; b < NUM_BANKS; b++) begin
            if (bank_hit[b]) soft_nxt[b] = soft_r[b] & ~lanes;
          end
        end
        vic_pkg::CMD_READ_STATUS: begin
          for (int b = 0; b < NUM_BANKS; b++) begin
            if (bank_hit[b]) res_beat.read_data = vic_pkg::DATA_W'(status[b]);
          end
        end
        vic_pkg::CMD_ACK: begin
          if (ack.found) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
              soft_nxt[b] = soft_r[b] & ~pick[b];
            end
            res_beat.vector       = ack.vector;
            res_beat.vector_valid = 1'b1;
          end else begin
            soft_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
    // pending summary reflects the state after this command
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (|((raw_nxt[b] | soft_nxt[b]) & en_nxt[b])) res_beat.any_pending = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= '0;
      raw_r  <= '0;
      soft_r <= '0;
    end else begin
      en_r   <= en_nxt;
      raw_r  <= raw_nxt;
      soft_r <= soft_nxt;
    end
  end

endmodule

@@ rtl/core/vic_out_q.sv @@
// vic_out_q: two-entry result queue between the core and the result port.
// Lets a new command beat enter while an earlier result is stalled. Uses vic_pkg.
module vic_out_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vic_pkg::out_beat_t push_beat,
  input  logic               pop,
  output vic_pkg::out_beat_t head_beat,
  output vic_pkg::q_stat_t   stat
);

  vic_pkg::out_beat_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
    stat.full  = (cnt_r == 2'd2);
    stat.empty = (cnt_r == 2'd0);
    head_beat  = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/vectored_interrupt_controller_unit.sv @@
// vectored_interrupt_controller_unit: top level of the banked interrupt controller.
// Depends on vic_pkg, vic_core (state, decode, priority encoder) and vic_out_q.
//
//   channel   dir   handshake            payload
//   in_       in    in_valid / in_stall  in_data  (vic_pkg::in_beat_t)
//   out_      out   out_valid / out_stall out_data (vic_pkg::out_beat_t)
//
// Cycles: one command beat per clock while in_stall is low. The command is decoded and the bank
// registers are updated at the accepting edge; its result is queued there
// and shows on out_ once the results queued ahead of it have been taken.
// Reset: rst_n low at a clock edge clears all enables, raw levels, soft
// bits and the result queue; ready for commands on the next cycle.
// Stalls: a two-entry result queue absorbs out_stall; in_stall rises only
// when both entries hold results not yet taken.
module vectored_interrupt_controller_unit #(
  parameter int NUM_BANKS      = vic_pkg::NUM_BANKS_DEF,
  parameter int LINES_PER_BANK = vic_pkg::LINES_PER_BANK_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vic_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vic_pkg::out_beat_t out_data
);

  logic               in_acc;
  logic               out_acc;
  vic_pkg::out_beat_t res_beat;
  vic_pkg::q_stat_t   q_stat;

  // accept whenever the queue has room; the core works in a single pass
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = q_stat.full;
  assign out_valid = !q_stat.empty;

  vic_core #(
    .NUM_BANKS      (NUM_BANKS),
    .LINES_PER_BANK (LINES_PER_BANK)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_acc  (in_acc),
    .cmd_beat (in_data),
    .res_beat (res_beat)
  );

  // result queue: the beat computed this cycle lands here at the same edge
  vic_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_beat (res_beat),
    .pop       (out_acc),
    .head_beat (out_data),
    .stat      (q_stat)
  );

  // a full queue always has a result on offer
  a_full_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("queue full with no result offered");

  // after an accepted command, a result is on offer on the next cycle
  a_acc_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted command produced no result");

  // vector is zero unless an acknowledge found a line
  a_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.vector_valid) |-> (out_data.vector == '0))
    else $error("vector set without vector_valid");

  // acknowledge and status read never share a result
  a_vec_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.vector_valid) |-> (out_data.read_data == '0))
    else $error("read data on an acknowledge result");

endmodule
